FILE: rtl/svd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types, constants and the sine table of the SVPWM duty calculator.
// ----------------------------------------------------------------------------
package svd_pkg;

  localparam int unsigned FULL_DUTY = 1500;
  localparam int unsigned HALF_DUTY = FULL_DUTY / 2;

  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned MOD_W   = 15;
  localparam int unsigned DUTY_W  = 11;
  localparam int unsigned TRIG_W  = 17;   // unsigned Q1.16, 1.0 is representable
  localparam int unsigned KM_W    = 31;
  localparam int unsigned T_W     = 12;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned IDX_W   = 7;

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam int unsigned     K_SQRT3_2   = 56756;
  // ceil(2^34 / 6): floor(x / 6) == (x * RECIP6) >> 34 for any 32-bit x.
  localparam longint unsigned RECIP6      = 64'd2863311531;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0] REG_MOD_DEPTH = 1'b0;

  typedef enum logic [2:0] {
    SECTOR_0,
    SECTOR_1,
    SECTOR_2,
    SECTOR_3,
    SECTOR_4,
    SECTOR_5
  } sector_t;

  typedef logic [TRIG_W-1:0] sin_tab_t [0:90];

  // Integer Taylor series of sin(d degrees), odd terms up to x^11, rounded to Q16.
  function automatic logic [TRIG_W-1:0] sin_deg(input int unsigned d);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned usum;
    int unsigned     n;
    x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 5; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    usum = longint'(sum);
    return TRIG_W'((usum + 64'd8192) >> 14);
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int i = 0; i <= 90; i++) begin
      tab[i] = sin_deg(i);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic logic [TRIG_W-1:0] sin_lookup(input logic [IDX_W-1:0] idx);
    logic [TRIG_W-1:0] val;
    val = '0;
    if (idx <= IDX_W'(90)) begin
      val = SIN_TAB[idx];
    end
    return val;
  endfunction

  typedef struct packed {
    sector_t             sector;
    logic                le90;    // 3a <= 90, so cos(3a) is not negative
    logic [TRIG_W-1:0]   s1;      // sin(60 - a)
    logic [TRIG_W-1:0]   s2;      // sin(a)
    logic [TRIG_W-1:0]   c;       // cos(a)
    logic [TRIG_W-1:0]   c3;      // |cos(3a)|
    logic [KM_W-1:0]     km;      // k * m, Q30
    logic [MOD_W-1:0]    m;
  } trig_t;

  typedef struct packed {
    sector_t          sector;
    logic [T_W-1:0]   t1;
    logic [T_W-1:0]   t2;
    logic [T_W-1:0]   t0;
  } term_t;

endpackage
`default_nettype wire

FILE: rtl/svd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_if
// Valid/ready channels for angle beats and duty beats.
// ----------------------------------------------------------------------------
interface svd_angle_if;
  logic                         valid;
  logic                         ready;
  logic [svd_pkg::ANGLE_W-1:0]  rotor_angle;

  modport source (output valid, output rotor_angle, input ready);
  modport sink   (input valid, input rotor_angle, output ready);
endinterface

interface svd_duty_if;
  logic                         valid;
  logic                         ready;
  logic [svd_pkg::DUTY_W-1:0]   duty_w;
  logic [svd_pkg::DUTY_W-1:0]   duty_u;
  logic [svd_pkg::DUTY_W-1:0]   duty_v;

  modport source (output valid, output duty_w, output duty_u, output duty_v, input ready);
  modport sink   (input valid, input duty_w, input duty_u, input duty_v, output ready);
endinterface
`default_nettype wire

FILE: rtl/svd_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_cfg
// APB register file holding the modulation index.
// ----------------------------------------------------------------------------
module svd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svd_pkg::PADDR_W-1:0]   paddr,
  input  logic [svd_pkg::PDATA_W-1:0]   pwdata,
  output logic [svd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [svd_pkg::MOD_W-1:0]     mod_depth
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[svd_pkg::PADDR_W-1:2] == svd_pkg::REG_MOD_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_depth <= '0;
    end else if (psel && penable && pwrite && pready && hit) begin
      mod_depth <= pwdata[svd_pkg::MOD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = svd_pkg::PDATA_W'(mod_depth);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/svd_trig.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_trig
// Front of the pipeline: sector split, then the sine table look-ups and k*m.
// ----------------------------------------------------------------------------
module svd_trig (
  input  logic                        clk,
  input  logic                        rst,
  svd_angle_if.sink                   angle,
  input  logic [svd_pkg::MOD_W-1:0]   m_cfg,
  output svd_pkg::trig_t              trig,
  output logic                        trig_valid,
  input  logic                        trig_ready
);

  // Stage A: sector and local angle.
  logic                        a_vld;
  logic                        a_ready;
  svd_pkg::sector_t            a_sector;
  logic [5:0]                  a_loc;
  logic [svd_pkg::MOD_W-1:0]   a_m;

  logic [svd_pkg::ANGLE_W-1:0] ang_w;
  svd_pkg::sector_t            sector_next;
  logic [svd_pkg::ANGLE_W-1:0] base;
  logic [svd_pkg::ANGLE_W-1:0] loc_full;

  // Stage B: table outputs.
  logic                        b_ready;
  logic [7:0]                  d3;
  logic [svd_pkg::IDX_W-1:0]   c3_idx;
  logic [svd_pkg::KM_W-1:0]    km_next;
  svd_pkg::trig_t              trig_next;

  assign a_ready     = !a_vld || b_ready;
  assign b_ready     = !trig_valid || trig_ready;
  assign angle.ready = a_ready;

  always_comb begin
    ang_w = angle.rotor_angle;
    if (angle.rotor_angle >= svd_pkg::ANGLE_W'(360)) begin
      ang_w = angle.rotor_angle - svd_pkg::ANGLE_W'(360);
    end
    if (ang_w >= svd_pkg::ANGLE_W'(300)) begin
      sector_next = svd_pkg::SECTOR_5;
      base        = svd_pkg::ANGLE_W'(300);
    end else if (ang_w >= svd_pkg::ANGLE_W'(240)) begin
      sector_next = svd_pkg::SECTOR_4;
      base        = svd_pkg::ANGLE_W'(240);
    end else if (ang_w >= svd_pkg::ANGLE_W'(180)) begin
      sector_next = svd_pkg::SECTOR_3;
      base        = svd_pkg::ANGLE_W'(180);
    end else if (ang_w >= svd_pkg::ANGLE_W'(120)) begin
      sector_next = svd_pkg::SECTOR_2;
      base        = svd_pkg::ANGLE_W'(120);
    end else if (ang_w >= svd_pkg::ANGLE_W'(60)) begin
      sector_next = svd_pkg::SECTOR_1;
      base        = svd_pkg::ANGLE_W'(60);
    end else begin
      sector_next = svd_pkg::SECTOR_0;
      base        = '0;
    end
    loc_full = ang_w - base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_ready) begin
      a_vld <= angle.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && angle.valid) begin
      a_sector <= sector_next;
      a_loc    <= loc_full[5:0];
      a_m      <= m_cfg;
    end
  end

  always_comb begin
    d3     = 8'(a_loc) * 8'd3;
    c3_idx = (d3 <= 8'd90) ? svd_pkg::IDX_W'(8'd90 - d3) : svd_pkg::IDX_W'(d3 - 8'd90);
    km_next = svd_pkg::KM_W'(svd_pkg::KM_W'(a_m) * svd_pkg::KM_W'(svd_pkg::K_SQRT3_2));
    trig_next.sector = a_sector;
    trig_next.le90   = (d3 <= 8'd90);
    trig_next.s1     = svd_pkg::sin_lookup(svd_pkg::IDX_W'(7'd60 - 7'(a_loc)));
    trig_next.s2     = svd_pkg::sin_lookup(svd_pkg::IDX_W'(a_loc));
    trig_next.c      = svd_pkg::sin_lookup(svd_pkg::IDX_W'(7'd90 - 7'(a_loc)));
    trig_next.c3     = svd_pkg::sin_lookup(c3_idx);
    trig_next.km     = km_next;
    trig_next.m      = a_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_valid <= 1'b0;
    end else if (b_ready) begin
      trig_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_vld) begin
      trig <= trig_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/svd_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_mul
// Product stages: scaled active times t1 and t2, and the zero time t0.
// ----------------------------------------------------------------------------
module svd_mul (
  input  logic             clk,
  input  logic             rst,
  input  svd_pkg::trig_t   trig,
  input  logic             trig_valid,
  output logic             trig_ready,
  output svd_pkg::term_t   term,
  output logic             term_valid,
  input  logic             term_ready
);

  // Stage C
  logic                   c_vld;
  logic                   c_ready;
  svd_pkg::sector_t       c_sector;
  logic                   c_le90;
  logic [30:0]            c_r1;
  logic [30:0]            c_r2;
  logic [31:0]            c_mc;
  logic [31:0]            c_mc3;
  logic [47:0]            p1;
  logic [47:0]            p2;

  // Stage D
  logic                   d_vld;
  logic                   d_ready;
  svd_pkg::sector_t       d_sector;
  logic                   d_le90;
  logic [svd_pkg::T_W-1:0] d_t1;
  logic [svd_pkg::T_W-1:0] d_t2;
  logic [31:0]            d_mc;
  logic [29:0]            d_third;
  logic [41:0]            q1;
  logic [41:0]            q2;
  logic [63:0]            q3;

  // Stage E
  logic                   e_vld;
  logic                   e_ready;
  svd_pkg::sector_t       e_sector;
  logic [svd_pkg::T_W-1:0] e_t1;
  logic [svd_pkg::T_W-1:0] e_t2;
  logic signed [33:0]     e_bracket;
  logic signed [33:0]     bracket_next;

  // Stage F
  logic                   f_ready;
  logic [42:0]            q0;
  svd_pkg::term_t         term_next;

  assign f_ready    = !term_valid || term_ready;
  assign e_ready    = !e_vld || f_ready;
  assign d_ready    = !d_vld || e_ready;
  assign c_ready    = !c_vld || d_ready;
  assign trig_ready = c_ready;

  assign p1 = 48'(trig.km) * 48'(trig.s1);
  assign p2 = 48'(trig.km) * 48'(trig.s2);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (c_ready) begin
      c_vld <= trig_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && trig_valid) begin
      c_sector <= trig.sector;
      c_le90   <= trig.le90;
      c_r1     <= p1[46:16];
      c_r2     <= p2[46:16];
      c_mc     <= 32'(trig.m) * 32'(trig.c);
      c_mc3    <= 32'(trig.m) * 32'(trig.c3);
    end
  end

  assign q1 = 42'(c_r1) * 42'(svd_pkg::FULL_DUTY);
  assign q2 = 42'(c_r2) * 42'(svd_pkg::FULL_DUTY);
  assign q3 = 64'(c_mc3) * svd_pkg::RECIP6;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (d_ready) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_vld) begin
      d_sector <= c_sector;
      d_le90   <= c_le90;
      d_t1     <= q1[41:30];
      d_t2     <= q2[41:30];
      d_mc     <= c_mc;
      d_third  <= q3[63:34];
    end
  end

  // The bracket 1 - m*cos(a) +/- m*|cos(3a)|/6 in signed Q30.
  always_comb begin
    bracket_next = 34'(svd_pkg::ONE_Q30) - $signed({2'b00, d_mc});
    if (d_le90) begin
      bracket_next = bracket_next + $signed({4'b0000, d_third});
    end else begin
      bracket_next = bracket_next - $signed({4'b0000, d_third});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (e_ready) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && d_vld) begin
      e_sector  <= d_sector;
      e_t1      <= d_t1;
      e_t2      <= d_t2;
      e_bracket <= bracket_next;
    end
  end

  // A positive bracket never exceeds 1.0, so t0 stays within half duty.
  assign q0 = 43'(e_bracket[32:0]) * 43'(svd_pkg::HALF_DUTY);

  always_comb begin
    term_next.sector = e_sector;
    term_next.t1     = e_t1;
    term_next.t2     = e_t2;
    term_next.t0     = e_bracket[33] ? '0 : q0[41:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else if (f_ready) begin
      term_valid <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && e_vld) begin
      term <= term_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/svd_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_mix
// Tail of the pipeline: t7, the per-sector phase pattern and saturation.
// ----------------------------------------------------------------------------
module svd_mix (
  input  logic             clk,
  input  logic             rst,
  input  svd_pkg::term_t   term,
  input  logic             term_valid,
  output logic             term_ready,
  svd_duty_if.source       duty
);

  localparam int unsigned SW = svd_pkg::SUM_W;

  // Stage G
  logic                    g_vld;
  logic                    g_ready;
  svd_pkg::sector_t        g_sector;
  logic [SW-1:0]           g_t1;
  logic [SW-1:0]           g_t2;
  logic [SW-1:0]           g_t0;
  logic [SW-1:0]           g_t7;
  logic [SW-1:0]           g_t12;
  logic [SW-1:0]           t12_next;
  logic [SW-1:0]           tot_next;
  logic [SW-1:0]           t7_next;

  // Stage H (output register)
  logic                    h_ready;
  logic [SW-1:0]           w_sum;
  logic [SW-1:0]           u_sum;
  logic [SW-1:0]           v_sum;

  function automatic logic [svd_pkg::DUTY_W-1:0] sat(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = v;
    if (v > SW'(svd_pkg::FULL_DUTY)) begin
      r = SW'(svd_pkg::FULL_DUTY);
    end
    return r[svd_pkg::DUTY_W-1:0];
  endfunction

  assign h_ready    = !duty.valid || duty.ready;
  assign g_ready    = !g_vld || h_ready;
  assign term_ready = g_ready;

  always_comb begin
    t12_next = SW'(term.t1) + SW'(term.t2);
    tot_next = t12_next + SW'(term.t0);
    t7_next  = '0;
    if (tot_next < SW'(svd_pkg::FULL_DUTY)) begin
      t7_next = SW'(svd_pkg::FULL_DUTY) - tot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (g_ready) begin
      g_vld <= term_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (g_ready && term_valid) begin
      g_sector <= term.sector;
      g_t1     <= SW'(term.t1);
      g_t2     <= SW'(term.t2);
      g_t0     <= SW'(term.t0);
      g_t7     <= t7_next;
      g_t12    <= t12_next;
    end
  end

  always_comb begin
    case (g_sector)
      svd_pkg::SECTOR_0: begin
        w_sum = g_t12 + g_t7;
        u_sum = g_t2 + g_t7;
        v_sum = g_t7;
      end
      svd_pkg::SECTOR_1: begin
        w_sum = g_t1 + g_t0;
        u_sum = g_t12 + g_t0;
        v_sum = g_t0;
      end
      svd_pkg::SECTOR_2: begin
        w_sum = g_t7;
        u_sum = g_t12 + g_t7;
        v_sum = g_t2 + g_t7;
      end
      svd_pkg::SECTOR_3: begin
        w_sum = g_t0;
        u_sum = g_t1 + g_t0;
        v_sum = g_t12 + g_t0;
      end
      svd_pkg::SECTOR_4: begin
        w_sum = g_t2 + g_t7;
        u_sum = g_t7;
        v_sum = g_t12 + g_t7;
      end
      default: begin
        w_sum = g_t12 + g_t0;
        u_sum = g_t0;
        v_sum = g_t1 + g_t0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty.valid <= 1'b0;
    end else if (h_ready) begin
      duty.valid <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (h_ready && g_vld) begin
      duty.duty_w <= sat(w_sum);
      duty.duty_u <= sat(u_sum);
      duty.duty_v <= sat(v_sum);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/svpwm_duty_calculation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_duty_calculation
// Space-vector PWM compare values from a rotor angle in whole degrees.
// ----------------------------------------------------------------------------
// The block takes one angle beat per clock unless stalled and returns one
// beat of three phase compare values through eight register stages: sector
// split, sine table look-ups with k*m, the k*m*sin and m*cos products, the
// duty scaling and divide-by-six reciprocal, the t0 bracket, t0, t7, and
// the sector pattern with saturation in the output register. Each stage has
// its own valid bit and holds its beat while the one after it is full, so a
// stalled output fills the pipeline before the input stops taking beats and
// nothing is lost or repeated. The modulation index (unsigned Q1.14) sits at
// APB byte address 0 and is sampled as each angle beat enters.
module svpwm_duty_calculation (
  input  logic                          clk,
  input  logic                          rst,
  svd_angle_if.sink                     angle,
  svd_duty_if.source                    duty,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svd_pkg::PADDR_W-1:0]   paddr,
  input  logic [svd_pkg::PDATA_W-1:0]   pwdata,
  output logic [svd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [svd_pkg::MOD_W-1:0] mod_depth;
  svd_pkg::trig_t            trig;
  logic                      trig_valid;
  logic                      trig_ready;
  svd_pkg::term_t            term;
  logic                      term_valid;
  logic                      term_ready;

  svd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .mod_depth (mod_depth)
  );

  svd_trig u_trig (
    .clk        (clk),
    .rst        (rst),
    .angle      (angle),
    .m_cfg      (mod_depth),
    .trig       (trig),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready)
  );

  svd_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .trig       (trig),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .term       (term),
    .term_valid (term_valid),
    .term_ready (term_ready)
  );

  svd_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .term       (term),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .duty       (duty)
  );

endmodule
`default_nettype wire
